[rtl/tetp_pkg.sv]
// ----------------------------------------------------------------------------
// tetp_pkg: shared types and constants for the touch event to pointer unit
// Event codes, fixed point widths, command item format, register indexes.
// ----------------------------------------------------------------------------
package tetp_pkg;

  localparam int FRAC_BITS = 8;
  localparam int RAW_W     = 32;
  localparam int SIZE_W    = 13;
  localparam int QUO_W     = SIZE_W + FRAC_BITS;   // scaled position < 2^(12+F)
  localparam int PROD_W    = RAW_W + SIZE_W;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int POS_W     = QUO_W + 1;            // signed internal position
  localparam int OUT_POS_W = 21;
  localparam int STAMP_W   = 62;
  localparam int SECS_W    = 32;
  localparam int MICROS_W  = 20;
  localparam int US_NS_W   = 30;
  localparam int CFG_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] SIZE_ONE = SIZE_W'(1);
  localparam logic signed [POS_W-1:0] POS_NONE = POS_W'(-(1 <<< FRAC_BITS));

  localparam logic [29:0] NS_PER_S  = 30'd1000000000;
  localparam logic [9:0]  NS_PER_US = 10'd1000;

  // event types and codes
  localparam logic [15:0] EV_SYNC       = 16'h0000;
  localparam logic [15:0] EV_KEY        = 16'h0001;
  localparam logic [15:0] EV_ABS        = 16'h0003;
  localparam logic [15:0] ABS_X         = 16'h0000;
  localparam logic [15:0] ABS_Y         = 16'h0001;
  localparam logic [15:0] ABS_MT_X      = 16'h0035;
  localparam logic [15:0] ABS_MT_Y      = 16'h0036;
  localparam logic [15:0] ABS_MT_TRACK  = 16'h0039;
  localparam logic [15:0] KEY_TOUCH     = 16'h014A;
  localparam logic [15:0] SYNC_REPORT   = 16'h0000;

  typedef enum logic [2:0] {
    REG_X_MIN, REG_X_MAX, REG_Y_MIN, REG_Y_MAX,
    REG_SCREEN_W, REG_SCREEN_H, REG_DIRECT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CMD_SET_X, CMD_SET_Y, CMD_PRESS, CMD_RELEASE, CMD_SYNC
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [RAW_W-1:0]      value;
    logic [SECS_W-1:0]     secs;
    logic [MICROS_W-1:0]   micros;
  } cmd_t;

endpackage

[rtl/tetp_front.sv]
// ----------------------------------------------------------------------------
// tetp_front: input decode
// Classifies each event item and pushes a command for the ones that matter.
// ----------------------------------------------------------------------------
module tetp_front import tetp_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_event_type,
  input  logic [15:0]       in_event_code,
  input  logic [RAW_W-1:0]  in_event_value,
  input  logic [SECS_W-1:0] in_time_seconds,
  input  logic [MICROS_W-1:0] in_time_micros,
  input  logic              direct_touch,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  logic hit;

  always_comb begin
    hit         = 1'b0;
    q_cmd.kind   = CMD_SYNC;
    q_cmd.value  = in_event_value;
    q_cmd.secs   = in_time_seconds;
    q_cmd.micros = in_time_micros;
    priority if (in_event_type == EV_ABS) begin
      priority if (in_event_code == ABS_X || in_event_code == ABS_MT_X) begin
        hit = 1'b1;
        q_cmd.kind = CMD_SET_X;
      end else if (in_event_code == ABS_Y || in_event_code == ABS_MT_Y) begin
        hit = 1'b1;
        q_cmd.kind = CMD_SET_Y;
      end else if (in_event_code == ABS_MT_TRACK) begin
        hit = 1'b1;
        q_cmd.kind = in_event_value[RAW_W-1] ? CMD_RELEASE : CMD_PRESS;
      end else begin
        hit = 1'b0;
      end
    end else if (in_event_type == EV_KEY && in_event_code == KEY_TOUCH) begin
      hit = 1'b1;
      q_cmd.kind = (in_event_value != '0) ? CMD_PRESS : CMD_RELEASE;
    end else if (in_event_type == EV_SYNC && in_event_code == SYNC_REPORT &&
                 direct_touch) begin
      hit = 1'b1;
      q_cmd.kind = CMD_SYNC;
    end else begin
      hit = 1'b0;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && hit;

endmodule

[rtl/tetp_queue.sv]
// ----------------------------------------------------------------------------
// tetp_queue: short command queue
// Two-entry FIFO between decode and execution.
// ----------------------------------------------------------------------------
module tetp_queue import tetp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic not_empty,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= PTR_W'((int'(wr_ptr_r) + 1) % QUEUE_DEPTH);
      if (pop)  rd_ptr_r <= PTR_W'((int'(rd_ptr_r) + 1) % QUEUE_DEPTH);
      if (push && !pop) count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

[rtl/tetp_div.sv]
// ----------------------------------------------------------------------------
// tetp_div: serial restoring divider
// One quotient bit per cycle; caller guarantees the quotient fits QUO_W bits.
// ----------------------------------------------------------------------------
module tetp_div import tetp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [RAW_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [RAW_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] low_r, quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [RAW_W:0]   trial;
  logic             ge;

  always_comb begin
    trial   = {rem_r, low_r[QUO_W-1]};
    ge      = (trial >= {1'b0, den});
    rem_nxt = ge ? RAW_W'(trial - {1'b0, den}) : trial[RAW_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num[NUM_W-1:QUO_W];
        low_r  <= num[QUO_W-1:0];
        cnt_r  <= CNT_W'(QUO_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        low_r <= {low_r[QUO_W-2:0], 1'b0};
        quo_r <= {quo_r[QUO_W-2:0], ge};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CNT_W'(1);
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[rtl/tetp_back.sv]
// ----------------------------------------------------------------------------
// tetp_back: command execution
// Holds touch state, scales both axes on a sync report and issues results.
// ----------------------------------------------------------------------------
module tetp_back import tetp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_not_empty,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  input  logic [RAW_W-1:0]      x_min,
  input  logic [RAW_W-1:0]      x_max,
  input  logic [RAW_W-1:0]      y_min,
  input  logic [RAW_W-1:0]      y_max,
  input  logic [SIZE_W-1:0]     screen_width,
  input  logic [SIZE_W-1:0]     screen_height,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_pointer_kind,
  output logic                  out_button_down,
  output logic [OUT_POS_W-1:0]  out_pos_x,
  output logic [OUT_POS_W-1:0]  out_pos_y,
  output logic [STAMP_W-1:0]    out_stamp_ns,
  output logic                  out_last_of_run
);

  typedef enum logic [2:0] {
    B_IDLE, B_PREP, B_MUL, B_DIV, B_AXIS, B_EMIT, B_OUT
  } state_t;

  typedef enum logic [1:0] {M_PRIOR, M_ZERO, M_TOP, M_DIV} mode_t;

  state_t state_r;
  mode_t  mode_r, pre_mode;

  logic [RAW_W-1:0]        raw_x_r, raw_y_r;
  logic                    x_chg_r, y_chg_r, contact_r, press_r, release_r;
  logic signed [POS_W-1:0] prior_x_r, prior_y_r, nx_r, ny_r;
  logic [SECS_W-1:0]       secs_r;
  logic [MICROS_W-1:0]     micros_r;
  logic [STAMP_W-1:0]      sec_ns_r, stamp_r;
  logic [US_NS_W-1:0]      us_ns_r;
  logic                    axis_r;
  logic [RAW_W-1:0]        diff_r, range_r;
  logic [SIZE_W-1:0]       size_r;
  logic [QUO_W-1:0]        top_r;
  logic [PROD_W-1:0]       prod_r;
  logic                    div_start_r, div_done;
  logic [QUO_W-1:0]        div_quo, quo_c;

  logic                    out_valid_r, out_kind_r, out_down_r, out_last_r;
  logic [OUT_POS_W-1:0]    out_x_r, out_y_r;
  logic [STAMP_W-1:0]      out_stamp_r;

  logic [RAW_W-1:0]        sel_raw, sel_lo, sel_hi;
  logic [SIZE_W-1:0]       sel_size, size_c;
  logic signed [POS_W-1:0] sel_prior, axis_val, rel_x, rel_y;
  logic [RAW_W:0]          range_w, diff_w;
  logic                    have_pos, out_free, out_load;

  // axis select and range checks
  always_comb begin
    sel_raw   = axis_r ? raw_y_r : raw_x_r;
    sel_lo    = axis_r ? y_min : x_min;
    sel_hi    = axis_r ? y_max : x_max;
    sel_size  = axis_r ? screen_height : screen_width;
    sel_prior = axis_r ? prior_y_r : prior_x_r;
    priority if (sel_size == '0)      size_c = SIZE_ONE;
    else if (sel_size > SIZE_MAX)     size_c = SIZE_MAX;
    else                              size_c = sel_size;
    range_w = {sel_hi[RAW_W-1], sel_hi} - {sel_lo[RAW_W-1], sel_lo};
    diff_w  = {sel_raw[RAW_W-1], sel_raw} - {sel_lo[RAW_W-1], sel_lo};
    priority if (range_w[RAW_W] || range_w == '0 || sel_raw[RAW_W-1]) pre_mode = M_PRIOR;
    else if (diff_w[RAW_W] || diff_w == '0)                           pre_mode = M_ZERO;
    else                                                              pre_mode = M_DIV;
  end

  always_comb begin
    quo_c = (div_quo > top_r) ? top_r : div_quo;
    unique case (mode_r)
      M_PRIOR: axis_val = sel_prior;
      M_ZERO:  axis_val = '0;
      M_TOP:   axis_val = {1'b0, top_r};
      M_DIV:   axis_val = {1'b0, quo_c};
      default: axis_val = sel_prior;
    endcase
  end

  assign have_pos = !nx_r[POS_W-1] && !ny_r[POS_W-1];
  assign rel_x    = nx_r[POS_W-1] ? prior_x_r : nx_r;
  assign rel_y    = ny_r[POS_W-1] ? prior_y_r : ny_r;
  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == B_IDLE) && q_not_empty;
  // a new result enters the output register this cycle
  assign out_load = (state_r == B_OUT && !out_stall) ||
                    (state_r == B_EMIT && out_free &&
                     (press_r || release_r ||
                      (contact_r && (x_chg_r || y_chg_r) && have_pos)));

  tetp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .num   ({prod_r, FRAC_BITS'(0)}),
    .den   (range_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      raw_x_r     <= '0;
      raw_y_r     <= '0;
      x_chg_r     <= 1'b0;
      y_chg_r     <= 1'b0;
      contact_r   <= 1'b0;
      press_r     <= 1'b0;
      release_r   <= 1'b0;
      prior_x_r   <= POS_NONE;
      prior_y_r   <= POS_NONE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      axis_r      <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      div_start_r <= (state_r == B_MUL) && (mode_r == M_DIV) && (diff_r < range_r);
      unique case (state_r)
        B_IDLE: begin
          if (q_not_empty) begin
            unique case (q_cmd.kind)
              CMD_SET_X: begin
                raw_x_r <= q_cmd.value;
                x_chg_r <= 1'b1;
              end
              CMD_SET_Y: begin
                raw_y_r <= q_cmd.value;
                y_chg_r <= 1'b1;
              end
              CMD_PRESS: begin
                contact_r <= 1'b1;
                press_r   <= 1'b1;
              end
              CMD_RELEASE: begin
                contact_r <= 1'b0;
                release_r <= 1'b1;
              end
              CMD_SYNC: begin
                secs_r   <= q_cmd.secs;
                micros_r <= q_cmd.micros;
                axis_r   <= 1'b0;
                state_r  <= B_PREP;
              end
              default: ;
            endcase
          end
        end
        B_PREP: begin
          mode_r  <= pre_mode;
          diff_r  <= diff_w[RAW_W-1:0];
          range_r <= range_w[RAW_W-1:0];
          size_r  <= size_c;
          top_r   <= QUO_W'(size_c - SIZE_ONE) << FRAC_BITS;
          if (!axis_r) sec_ns_r <= STAMP_W'(secs_r) * STAMP_W'(NS_PER_S);
          state_r <= B_MUL;
        end
        B_MUL: begin
          prod_r <= PROD_W'(diff_r) * PROD_W'(size_r);
          if (!axis_r) us_ns_r <= US_NS_W'(micros_r) * US_NS_W'(NS_PER_US);
          if (mode_r == M_DIV && diff_r >= range_r) begin
            mode_r  <= M_TOP;
            state_r <= B_AXIS;
          end else if (mode_r == M_DIV) begin
            state_r <= B_DIV;
          end else begin
            state_r <= B_AXIS;
          end
        end
        B_DIV: begin
          if (div_done) state_r <= B_AXIS;
        end
        B_AXIS: begin
          if (!axis_r) begin
            nx_r    <= axis_val;
            stamp_r <= sec_ns_r + STAMP_W'(us_ns_r);
            axis_r  <= 1'b1;
            state_r <= B_PREP;
          end else begin
            ny_r    <= axis_val;
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            out_stamp_r <= stamp_r;
            x_chg_r     <= 1'b0;
            y_chg_r     <= 1'b0;
            state_r     <= B_IDLE;
            priority if (press_r) begin
              press_r     <= 1'b0;
              prior_x_r   <= nx_r;
              prior_y_r   <= ny_r;
              out_x_r     <= nx_r[OUT_POS_W-1:0];
              out_y_r     <= ny_r[OUT_POS_W-1:0];
              if (have_pos) begin
                // motion first, button-down follows
                out_kind_r <= 1'b0;
                out_down_r <= 1'b0;
                out_last_r <= 1'b0;
                state_r    <= B_OUT;
              end else begin
                out_kind_r <= 1'b1;
                out_down_r <= 1'b1;
                out_last_r <= 1'b1;
              end
            end else if (release_r) begin
              release_r   <= 1'b0;
              prior_x_r   <= POS_NONE;
              prior_y_r   <= POS_NONE;
              out_kind_r  <= 1'b1;
              out_down_r  <= 1'b0;
              out_last_r  <= 1'b1;
              out_x_r     <= rel_x[OUT_POS_W-1:0];
              out_y_r     <= rel_y[OUT_POS_W-1:0];
            end else if (contact_r && (x_chg_r || y_chg_r) && have_pos) begin
              prior_x_r   <= nx_r;
              prior_y_r   <= ny_r;
              out_kind_r  <= 1'b0;
              out_down_r  <= 1'b0;
              out_last_r  <= 1'b1;
              out_x_r     <= nx_r[OUT_POS_W-1:0];
              out_y_r     <= ny_r[OUT_POS_W-1:0];
            end else begin
              out_last_r <= out_last_r;
            end
          end
        end
        B_OUT: begin
          if (!out_stall) begin
            out_kind_r  <= 1'b1;
            out_down_r  <= 1'b1;
            out_last_r  <= 1'b1;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pointer_kind = out_kind_r;
  assign out_button_down  = out_down_r;
  assign out_pos_x        = out_x_r;
  assign out_pos_y        = out_y_r;
  assign out_stamp_ns     = out_stamp_r;
  assign out_last_of_run  = out_last_r;

endmodule

[rtl/touch_event_to_pointer_unit.sv]
// ----------------------------------------------------------------------------
// touch_event_to_pointer_unit: touch events to pointer results
// Decode front, two-entry command queue, sequential execution back end.
// ----------------------------------------------------------------------------
// Position and contact items update the touch state as they leave the queue.
// A sync report is handled per axis, x then y: prep, a 32x13 multiply, a
// serial divide (start, 21 steps, done) when that axis divides, and a select;
// then its results are issued. Other items are taken one per cycle while the
// back end is idle; it takes no new command until a sync report is through.
// Reset (synchronous, rst_n low): queue empty, touch state cleared, prior
// position set to none, registers at their defaults, no result pending.
module touch_event_to_pointer_unit import tetp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  // event items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [15:0]                 in_event_type,
  input  logic [15:0]                 in_event_code,
  input  logic signed [RAW_W-1:0]     in_event_value,
  input  logic [SECS_W-1:0]           in_time_seconds,
  input  logic [MICROS_W-1:0]         in_time_micros,
  // pointer result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_pointer_kind,
  output logic                        out_button_down,
  output logic signed [OUT_POS_W-1:0] out_pos_x,
  output logic signed [OUT_POS_W-1:0] out_pos_y,
  output logic [STAMP_W-1:0]          out_stamp_ns,
  output logic                        out_last_of_run,
  // register writes
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [RAW_W-1:0]            cfg_wdata
);

  // configuration registers
  logic [RAW_W-1:0]  x_min_r, x_max_r, y_min_r, y_max_r;
  logic [SIZE_W-1:0] screen_w_r, screen_h_r;
  logic              direct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r    <= '0;
      x_max_r    <= RAW_W'(4095);
      y_min_r    <= '0;
      y_max_r    <= RAW_W'(4095);
      screen_w_r <= SIZE_W'(1024);
      screen_h_r <= SIZE_W'(768);
      direct_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_MIN:    x_min_r    <= cfg_wdata;
        REG_X_MAX:    x_max_r    <= cfg_wdata;
        REG_Y_MIN:    y_min_r    <= cfg_wdata;
        REG_Y_MAX:    y_max_r    <= cfg_wdata;
        REG_SCREEN_W: screen_w_r <= cfg_wdata[SIZE_W-1:0];
        REG_SCREEN_H: screen_h_r <= cfg_wdata[SIZE_W-1:0];
        REG_DIRECT:   direct_r   <= cfg_wdata[0];
        default: ;    // unused index, write dropped
      endcase
    end
  end

  // front -> queue -> back
  logic q_push, q_full, q_not_empty, q_pop;
  cmd_t push_cmd, pop_cmd;
  logic [OUT_POS_W-1:0] pos_x_u, pos_y_u;

  // sync reports are dropped here when not a direct touch device
  tetp_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_event_type   (in_event_type),
    .in_event_code   (in_event_code),
    .in_event_value  (in_event_value),
    .in_time_seconds (in_time_seconds),
    .in_time_micros  (in_time_micros),
    .direct_touch    (direct_r),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  tetp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd)
  );

  // back end owns all touch state and the output register
  tetp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_not_empty      (q_not_empty),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .x_min            (x_min_r),
    .x_max            (x_max_r),
    .y_min            (y_min_r),
    .y_max            (y_max_r),
    .screen_width     (screen_w_r),
    .screen_height    (screen_h_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pointer_kind (out_pointer_kind),
    .out_button_down  (out_button_down),
    .out_pos_x        (pos_x_u),
    .out_pos_y        (pos_y_u),
    .out_stamp_ns     (out_stamp_ns),
    .out_last_of_run  (out_last_of_run)
  );

  assign out_pos_x = signed'(pos_x_u);
  assign out_pos_y = signed'(pos_y_u);

endmodule

[rtl/tetp_check.sv]
// ----------------------------------------------------------------------------
// tetp_check: port-level checks for touch_event_to_pointer_unit
// Watches the result channel; bound to the top level.
// ----------------------------------------------------------------------------
module tetp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_pointer_kind,
  input logic        out_button_down,
  input logic [20:0] out_pos_x,
  input logic [20:0] out_pos_y,
  input logic [61:0] out_stamp_ns,
  input logic        out_last_of_run
);

  // held result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pos_x) && $stable(out_pos_y) &&
                               $stable(out_stamp_ns) && $stable(out_pointer_kind))
    else $error("stalled result changed");

  // motion always carries a real position and no button state
  a_motion: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pointer_kind |->
      !out_button_down && !out_pos_x[20] && !out_pos_y[20])
    else $error("bad motion result");

  // a non-final result is the motion of a press; button-down follows at once
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
      out_valid && out_pointer_kind && out_button_down && out_last_of_run)
    else $error("press pair broken");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind touch_event_to_pointer_unit tetp_check u_check (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_pointer_kind (out_pointer_kind),
  .out_button_down  (out_button_down),
  .out_pos_x        (out_pos_x),
  .out_pos_y        (out_pos_y),
  .out_stamp_ns     (out_stamp_ns),
  .out_last_of_run  (out_last_of_run)
);
